// ----- hw/rtl/csfw_pkg.sv -----
package csfw_pkg;

	localparam int VALUE_W = 16;
	localparam int COUNT_W = 15;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = 16'sh7fff;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 16'sh8000;

	localparam logic CMD_WAIT   = 1'b0;
	localparam logic CMD_SIGNAL = 1'b1;

	localparam logic signed [VALUE_W-1:0] VALUE_RESET = 16'sd1;

	typedef enum logic [2:0] {
		ST_ACQUIRED  = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_WOKE      = 3'd4,
		ST_NO_WAITER = 3'd5
	} status_t;

endpackage

// ----- hw/rtl/csfw_ram.sv -----
module csfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/counting_semaphore_fifo_waiters.sv -----
// Counting semaphore with a FIFO of blocked requester IDs. One transaction is
// taken per cycle (busy stays low); its result appears on the result ports with
// done high in the cycle after it was accepted, the delay being the registered
// read of the waiter RAM that supplies woken_id. The receiver cannot
// stall, so results must be consumed the cycle they are shown. A write to
// cfg_wdata reloads the semaphore value at once and leaves the queue untouched;
// it must only be issued while no transaction is in flight. The waiter RAM has
// no reset; only entries that were queued ever reach woken_id.
module counting_semaphore_fifo_waiters #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [csfw_pkg::COUNT_W-1:0]     cfg_wdata,
	input  logic                             start,
	output logic                             busy,
	input  logic                             command,
	input  logic [ID_WIDTH-1:0]              requester,
	output logic                             done,
	output logic [2:0]                       status,
	output logic [ID_WIDTH-1:0]              woken_id,
	output logic signed [csfw_pkg::VALUE_W-1:0] current_value,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] waiting_count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

	logic signed [csfw_pkg::VALUE_W-1:0] value_q, nxt_value;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [OCC_W-1:0] occ_q, nxt_occ;

	logic accept, push, pop;
	csfw_pkg::status_t nxt_status;

	logic valid_s1, pop_s1;
	csfw_pkg::status_t status_s1;
	logic signed [csfw_pkg::VALUE_W-1:0] value_s1;
	logic [OCC_W-1:0] occ_s1;
	logic [ID_WIDTH-1:0] rd_id;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		nxt_value  = value_q;
		nxt_occ    = occ_q;
		push       = 1'b0;
		pop        = 1'b0;
		nxt_status = csfw_pkg::ST_ACQUIRED;
		if (command == csfw_pkg::CMD_WAIT) begin
			if (value_q != csfw_pkg::VAL_MIN) begin
				nxt_value = value_q - 16'sd1;
			end
			if (nxt_value[csfw_pkg::VALUE_W-1]) begin
				if (occ_q != OCC_FULL) begin
					push       = accept;
					nxt_occ    = occ_q + OCC_W'(1);
					nxt_status = csfw_pkg::ST_QUEUED;
				end else begin
					nxt_status = csfw_pkg::ST_DROPPED;
				end
			end
		end else begin
			if (value_q != csfw_pkg::VAL_MAX) begin
				nxt_value = value_q + 16'sd1;
			end
			if (nxt_value[csfw_pkg::VALUE_W-1] || nxt_value == '0) begin
				if (occ_q != '0) begin
					pop        = accept;
					nxt_occ    = occ_q - OCC_W'(1);
					nxt_status = csfw_pkg::ST_WOKE;
				end else begin
					nxt_status = csfw_pkg::ST_NO_WAITER;
				end
			end else begin
				nxt_status = csfw_pkg::ST_RELEASED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q  <= csfw_pkg::VALUE_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			valid_s1 <= 1'b0;
			pop_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			pop_s1   <= pop;
			if (cfg_we) begin
				value_q <= {1'b0, cfg_wdata};
			end else if (accept) begin
				value_q <= nxt_value;
				occ_q   <= nxt_occ;
			end
			if (push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
			end
			if (pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= nxt_status;
			value_s1  <= nxt_value;
			occ_s1    <= nxt_occ;
		end
	end

	csfw_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_waiters (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata(requester),
		.raddr(head_q),
		.rdata(rd_id)
	);

	assign done          = valid_s1;
	assign status        = status_s1;
	assign woken_id      = pop_s1 ? rd_id : '0;
	assign current_value = value_s1;
	assign waiting_count = occ_s1;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("wait queue occupancy beyond depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result missing after transaction");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without transaction");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_s1 == csfw_pkg::ST_DROPPED) |-> (occ_s1 == OCC_FULL))
		else $error("drop reported with room in queue");

	a_occ_change: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(occ_q) && $stable(head_q) && $stable(tail_q))
		else $error("queue state moved without transaction");

endmodule

// ----- tb/tb_counting_semaphore_fifo_waiters.sv -----
module tb_counting_semaphore_fifo_waiters;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WAITER_DEPTH = 16;
	localparam int STALL_LIMIT  = 2000;
	localparam int IDLE_PCT     = 13;
	localparam int RAND_PHASES  = 7;
	localparam int PHASE_ITEMS  = 93;

	typedef struct packed {
		csfw_pkg::status_t                   st;
		logic [7:0]                          woken;
		logic signed [csfw_pkg::VALUE_W-1:0] value;
		logic [4:0]                          count;
	} sem_result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                    kind;
		logic                         cmd;
		logic [7:0]                   pid;
		int unsigned                  reps;
		logic [csfw_pkg::COUNT_W-1:0] cfg;
		logic                         typed;
		sem_result_t                  want;
	} stim_row_t;

	localparam sem_result_t NO_RES = '{csfw_pkg::ST_ACQUIRED, 8'h00, 16'sd0, 5'd0};

	logic                                clk           = 1'b0;
	logic                                arst_n        = 1'b0;
	logic                                cfg_we        = 1'b0;
	logic [csfw_pkg::COUNT_W-1:0]        cfg_wdata     = '0;
	logic                                start         = 1'b0;
	logic                                busy;
	logic                                command       = csfw_pkg::CMD_WAIT;
	logic [7:0]                          requester     = 8'h00;
	logic                                done;
	logic [2:0]                          status;
	logic [7:0]                          woken_id;
	logic signed [csfw_pkg::VALUE_W-1:0] current_value;
	logic [4:0]                          waiting_count;

	counting_semaphore_fifo_waiters dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.requester    (requester),
		.done         (done),
		.status       (status),
		.woken_id     (woken_id),
		.current_value(current_value),
		.waiting_count(waiting_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic signed [csfw_pkg::VALUE_W-1:0] sem_value = csfw_pkg::VALUE_RESET;
	logic [7:0]                          blocked_ids[$];

	sem_result_t pending_results[$];
	sem_result_t oldest;
	int          mismatches   = 0;
	int          stall_cycles = 0;
	bit          idle_on      = 1'b1;

	stim_row_t script[0:18] = '{
		'{ROW_REQ, csfw_pkg::CMD_WAIT,   8'h00, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_ACQUIRED, 8'h00, 16'sd0, 5'd0}},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'hff, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_RELEASED, 8'h00, 16'sd1, 5'd0}},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'ha5, 1,  15'd0, 1'b0, NO_RES},
		'{ROW_REQ, csfw_pkg::CMD_WAIT,   8'h5a, 3,  15'd0, 1'b0, NO_RES},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'h3c, 2,  15'd0, 1'b0, NO_RES},
		'{ROW_CFG, csfw_pkg::CMD_WAIT,   8'h00, 1,  15'h7fff, 1'b0, NO_RES},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'h7f, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_RELEASED, 8'h00, csfw_pkg::VAL_MAX, 5'd0}},
		'{ROW_REQ, csfw_pkg::CMD_WAIT,   8'hc3, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_ACQUIRED, 8'h00, 16'sd32766, 5'd0}},
		'{ROW_CFG, csfw_pkg::CMD_WAIT,   8'h00, 1,  15'd0, 1'b0, NO_RES},
		'{ROW_REQ, csfw_pkg::CMD_WAIT,   8'h10, 17, 15'd0, 1'b0, NO_RES},
		'{ROW_REQ, csfw_pkg::CMD_WAIT,   8'hee, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_DROPPED, 8'h00, -16'sd18, 5'd16}},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'h20, 16, 15'd0, 1'b0, NO_RES},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'h55, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_NO_WAITER, 8'h00, -16'sd1, 5'd0}},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'haa, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_NO_WAITER, 8'h00, 16'sd0, 5'd0}},
		'{ROW_REQ, csfw_pkg::CMD_WAIT,   8'h01, 3,  15'd0, 1'b0, NO_RES},
		'{ROW_CFG, csfw_pkg::CMD_WAIT,   8'h00, 1,  15'd5, 1'b0, NO_RES},
		'{ROW_REQ, csfw_pkg::CMD_SIGNAL, 8'h66, 1,  15'd0, 1'b1,
			'{csfw_pkg::ST_RELEASED, 8'h00, 16'sd6, 5'd3}},
		'{ROW_CFG, csfw_pkg::CMD_WAIT,   8'h00, 1,  15'd0, 1'b0, NO_RES},
		'{ROW_CFG, csfw_pkg::CMD_WAIT,   8'h00, 1,  15'd1, 1'b0, NO_RES}
	};

	function automatic sem_result_t apply_request(input logic cmd, input logic [7:0] pid);
		sem_result_t r;
		r.woken = 8'h00;
		if (cmd == csfw_pkg::CMD_WAIT) begin
			if (sem_value != csfw_pkg::VAL_MIN)
				sem_value = sem_value - 16'sd1;
			if (sem_value < 16'sd0) begin
				if (blocked_ids.size() < WAITER_DEPTH) begin
					blocked_ids.push_back(pid);
					r.st = csfw_pkg::ST_QUEUED;
				end else begin
					r.st = csfw_pkg::ST_DROPPED;
				end
			end else begin
				r.st = csfw_pkg::ST_ACQUIRED;
			end
		end else begin
			if (sem_value != csfw_pkg::VAL_MAX)
				sem_value = sem_value + 16'sd1;
			if (sem_value <= 16'sd0) begin
				if (blocked_ids.size() != 0) begin
					r.woken = blocked_ids.pop_front();
					r.st = csfw_pkg::ST_WOKE;
				end else begin
					r.st = csfw_pkg::ST_NO_WAITER;
				end
			end else begin
				r.st = csfw_pkg::ST_RELEASED;
			end
		end
		r.value = sem_value;
		r.count = 5'(blocked_ids.size());
		return r;
	endfunction

	task automatic issue_request(input logic cmd, input logic [7:0] pid, input logic typed,
			input sem_result_t typed_res);
		sem_result_t r;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		command   <= cmd;
		requester <= pid;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = apply_request(cmd, pid);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic write_count(input logic [csfw_pkg::COUNT_W-1:0] val);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		sem_value = {1'b0, val};
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: status %0d woken %0h value %0d count %0d",
						status, woken_id, current_value, waiting_count);
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.st || woken_id !== oldest.woken ||
						current_value !== oldest.value || waiting_count !== oldest.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st %0d id %0h val %0d cnt %0d, got %0d %0h %0d %0d",
							oldest.st, oldest.woken, oldest.value, oldest.count,
							status, woken_id, current_value, waiting_count);
				end
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned wait_pct;
		logic [csfw_pkg::COUNT_W-1:0] cv;
		logic cmd;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				write_count(script[i].cfg);
			end else begin
				for (int unsigned k = 0; k < script[i].reps; k++)
					issue_request(script[i].cmd, 8'(script[i].pid + k), script[i].typed,
						script[i].want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: cv = 15'd0;
				1: cv = 15'h7fff;
				2: cv = 15'($urandom_range(0, 32767));
				default: cv = 15'($urandom_range(0, 20));
			endcase
			write_count(cv);
			case ($urandom_range(3))
				0: wait_pct = 30;
				1: wait_pct = 70;
				default: wait_pct = 50;
			endcase
			idle_on = (ph != 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				cmd = ($urandom_range(99) < wait_pct) ? csfw_pkg::CMD_WAIT : csfw_pkg::CMD_SIGNAL;
				issue_request(cmd, 8'($urandom), 1'b0, NO_RES);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/csfw_pkg.sv
hw/rtl/csfw_ram.sv
hw/rtl/counting_semaphore_fifo_waiters.sv
tb/tb_counting_semaphore_fifo_waiters.sv
